// ===== rtl/shs_pkg.sv =====
// Shared types and constants of the section header splitter.
// Holds counter, location, line phase, record-run and queue definitions used by all modules.
// No dependencies.
package shs_pkg;

    localparam int CNT_W = 32;
    typedef logic [CNT_W-1:0] t_cnt;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LINE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COL  = 1'b1;

    localparam logic [2:0] PH_LEAD   = 3'd0;
    localparam logic [2:0] PH_NAME   = 3'd1;
    localparam logic [2:0] PH_TAIL   = 3'd2;
    localparam logic [2:0] PH_REJECT = 3'd3;
    localparam logic [2:0] PH_PEND   = 3'd4;

    typedef struct packed {
        t_cnt off;
        t_cnt line;
        t_cnt col;
    } t_mark;

    typedef struct packed {
        t_cnt start_off;
        t_cnt end_off;
        t_cnt line;
        t_cnt first_col;
        t_cnt colon_col;
    } t_name;

    // Candidate records of one byte, in output order.
    localparam int NUM_CAND = 6;
    localparam int CAND_W   = $clog2(NUM_CAND);
    typedef logic [CAND_W-1:0] t_cand;
    localparam t_cand CAND_HDR_CR    = t_cand'(0);
    localparam t_cand CAND_END_BREAK = t_cand'(1);
    localparam t_cand CAND_HDR_LF    = t_cand'(2);
    localparam t_cand CAND_END_EOB   = t_cand'(3);
    localparam t_cand CAND_HDR_EOB   = t_cand'(4);
    localparam t_cand CAND_END_FINAL = t_cand'(5);

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_END    = 1'b1;
    localparam logic [NUM_CAND-1:0] CAND_KIND = {KIND_END, KIND_HEADER, KIND_END,
                                                 KIND_HEADER, KIND_END, KIND_HEADER};

    // mark_a: header closed by the byte after CR; mark_l: line start;
    // mark_p: position after the byte.
    typedef struct packed {
        logic [NUM_CAND-1:0] en;
        t_name               name;
        t_mark               mark_a;
        t_mark               mark_l;
        t_mark               mark_p;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== rtl/shs_front.sv =====
// Front end: per-byte line tracking, header line recognizer and configuration registers.
// Produces one record-run bundle per byte that causes records.
// Depends on shs_pkg.
module shs_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_end_of_body,
    input  logic                             i_cfg_wr,
    input  logic [shs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  shs_pkg::t_cnt                    i_cfg_data,
    output logic                             o_push,
    output shs_pkg::t_bundle                 o_bundle
);
    import shs_pkg::*;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_HYPH  = 8'h2D;

    localparam t_cnt CNT_ONE = t_cnt'(1);

    function automatic t_cnt sat_inc(input t_cnt x);
        return (x == '1) ? x : x + CNT_ONE;
    endfunction

    function automatic logic is_word(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h30 && b <= 8'h39) || b == CH_UNDER || b == CH_HYPH;
    endfunction

    t_cnt       r_start_line, r_start_col, n_start_line, n_start_col;
    t_cnt       r_off, r_line, r_col, n_off, n_line, n_col;
    logic [2:0] r_phase, n_phase;
    logic       r_after_cr, n_after_cr;
    logic       r_open, n_open;
    logic       r_fresh;
    t_mark      r_mark, n_mark;
    t_name      r_name, n_name;

    t_cnt                w_off_inc, w_line_inc, w_col_inc;
    logic                w_is_cr, w_is_lf, w_is_ws, w_is_word, w_is_colon;
    logic                w_hdr0, w_done, w_tail, w_open1, w_open2, w_eob_hdr;
    logic [2:0]          w_phase1;
    t_mark               w_mark_a, w_mark1;
    logic [NUM_CAND-1:0] w_en;

    always_comb begin
        n_start_line = (i_cfg_wr && i_cfg_index == CFG_START_LINE) ? i_cfg_data : r_start_line;
        n_start_col  = (i_cfg_wr && i_cfg_index == CFG_START_COL)  ? i_cfg_data : r_start_col;
    end

    always_comb begin
        w_off_inc  = sat_inc(r_off);
        w_line_inc = sat_inc(r_line);
        w_col_inc  = sat_inc(r_col);
        w_is_cr    = i_data_byte == CH_CR;
        w_is_lf    = i_data_byte == CH_LF;
        w_is_ws    = i_data_byte == CH_SP || i_data_byte == CH_TAB;
        w_is_colon = i_data_byte == CH_COLON;
        w_is_word  = is_word(i_data_byte);

        // pending break after CR resolves first
        w_hdr0   = r_after_cr && (r_phase == PH_PEND);
        w_done   = r_after_cr && w_is_lf;
        w_phase1 = r_after_cr ? PH_LEAD : r_phase;
        w_mark_a = '{w_done ? w_off_inc : r_off, r_line, r_col};
        w_mark1  = r_after_cr ? w_mark_a : r_mark;
        w_open1  = r_open || w_hdr0;

        n_off      = w_off_inc;
        n_line     = r_line;
        n_col      = r_col;
        n_phase    = w_phase1;
        n_after_cr = 1'b0;
        n_mark     = w_mark1;
        n_name     = r_name;
        w_tail     = 1'b0;
        w_en       = '0;
        w_en[CAND_HDR_CR] = w_hdr0;

        if (!w_done) begin
            if (w_is_cr || w_is_lf) begin
                w_tail = w_phase1 == PH_TAIL;
                w_en[CAND_END_BREAK] = w_tail && w_open1;
                n_line = w_line_inc;
                n_col  = CNT_ONE;
                if (w_is_lf) begin
                    w_en[CAND_HDR_LF] = w_tail;
                    n_mark  = '{w_off_inc, w_line_inc, CNT_ONE};
                    n_phase = PH_LEAD;
                end else begin
                    n_after_cr = 1'b1;
                    n_phase    = w_tail ? PH_PEND : PH_LEAD;
                end
            end else begin
                n_col = w_col_inc;
                unique case (w_phase1)
                    PH_LEAD: begin
                        if (w_is_word) begin
                            n_name.start_off = r_off;
                            n_name.line      = r_line;
                            n_name.first_col = r_col;
                            n_phase          = PH_NAME;
                        end else if (!w_is_ws) begin
                            n_phase = PH_REJECT;
                        end
                    end
                    PH_NAME: begin
                        if (w_is_colon) begin
                            n_name.end_off   = r_off;
                            n_name.colon_col = r_col;
                            n_phase          = PH_TAIL;
                        end else if (!w_is_word) begin
                            n_phase = PH_REJECT;
                        end
                    end
                    PH_TAIL: begin
                        if (!w_is_ws) begin
                            n_phase = PH_REJECT;
                        end
                    end
                    default: begin
                        n_phase = PH_REJECT;
                    end
                endcase
            end
        end

        w_open2   = w_open1 || w_en[CAND_HDR_LF];
        w_eob_hdr = (n_after_cr && n_phase == PH_PEND) || (!n_after_cr && n_phase == PH_TAIL);
        w_en[CAND_END_EOB]   = i_end_of_body && !n_after_cr && (n_phase == PH_TAIL) && w_open2;
        w_en[CAND_HDR_EOB]   = i_end_of_body && w_eob_hdr;
        w_en[CAND_END_FINAL] = i_end_of_body && (w_open2 || w_eob_hdr);
        n_open = w_open2;
    end

    always_comb begin
        o_push          = i_accept && (w_en != '0);
        o_bundle.en     = w_en;
        o_bundle.name   = w_hdr0 ? r_name : n_name;
        o_bundle.mark_a = w_mark_a;
        o_bundle.mark_l = w_mark1;
        o_bundle.mark_p = '{n_off, n_line, n_col};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_line <= CNT_ONE;
            r_start_col  <= CNT_ONE;
            r_off        <= '0;
            r_line       <= CNT_ONE;
            r_col        <= CNT_ONE;
            r_phase      <= PH_LEAD;
            r_after_cr   <= 1'b0;
            r_open       <= 1'b0;
            r_fresh      <= 1'b1;
            r_mark       <= '{'0, CNT_ONE, CNT_ONE};
        end else begin
            r_start_line <= n_start_line;
            r_start_col  <= n_start_col;
            if ((i_accept && i_end_of_body) || (!i_accept && i_cfg_wr && r_fresh)) begin
                // start of a new body
                r_off      <= '0;
                r_line     <= n_start_line;
                r_col      <= n_start_col;
                r_phase    <= PH_LEAD;
                r_after_cr <= 1'b0;
                r_open     <= 1'b0;
                r_fresh    <= 1'b1;
                r_mark     <= '{'0, n_start_line, n_start_col};
            end else if (i_accept) begin
                r_off      <= n_off;
                r_line     <= n_line;
                r_col      <= n_col;
                r_phase    <= n_phase;
                r_after_cr <= n_after_cr;
                r_open     <= n_open;
                r_fresh    <= 1'b0;
                r_mark     <= n_mark;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_name <= n_name;
        end
    end

    a_pend_after_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PEND) |-> r_after_cr)
        else $error("pending header without a CR in flight");

    a_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> ($countones(o_bundle.en) <= 3))
        else $error("more than three records from one byte");

endmodule

// ===== rtl/shs_queue.sv =====
// Short bundle queue between the front end and the record serializer.
// Register-based FIFO of QUEUE_DEPTH record-run bundles.
// Depends on shs_pkg.
module shs_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  shs_pkg::t_bundle  i_bundle,
    input  logic              i_pop,
    output shs_pkg::t_bundle  o_head,
    output shs_pkg::t_q_stat  o_stat
);
    import shs_pkg::*;

    localparam logic [QUEUE_AW-1:0] PTR_LAST = QUEUE_AW'(QUEUE_DEPTH - 1);
    localparam logic [QUEUE_CW-1:0] CNT_FULL = QUEUE_CW'(QUEUE_DEPTH);

    t_bundle             r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_CW-1:0] r_count;

    always_comb begin
        o_head       = r_mem[r_rd];
        o_stat.full  = r_count == CNT_FULL;
        o_stat.empty = r_count == '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push |-> !o_stat.full) and (i_pop |-> !o_stat.empty))
        else $error("queue overflow or underflow");

endmodule

// ===== rtl/shs_back.sv =====
// Back end: walks the records of the head bundle in order, one per transaction.
// Holds the output register; pops a bundle after its last record.
// Depends on shs_pkg.
module shs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  shs_pkg::t_bundle  i_head,
    input  shs_pkg::t_q_stat  i_q_stat,
    output logic              o_pop,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic              o_record_kind,
    output shs_pkg::t_cnt     o_name_start_offset,
    output shs_pkg::t_cnt     o_name_end_offset,
    output shs_pkg::t_cnt     o_name_line,
    output shs_pkg::t_cnt     o_name_first_column,
    output shs_pkg::t_cnt     o_name_colon_column,
    output shs_pkg::t_cnt     o_mark_offset,
    output shs_pkg::t_cnt     o_mark_line,
    output shs_pkg::t_cnt     o_mark_column,
    output logic              o_last_of_run
);
    import shs_pkg::*;

    logic [NUM_CAND-1:0] r_done;
    logic                r_out_valid;
    logic                r_kind, r_last;
    t_name               r_name;
    t_mark               r_mark;

    logic [NUM_CAND-1:0] w_pend, w_sel_oh;
    t_cand               w_sel;
    logic                w_found, w_last, w_load, w_kind;
    t_mark               w_mark;

    always_comb begin
        w_pend   = i_head.en & ~r_done;
        w_sel    = '0;
        w_sel_oh = '0;
        w_found  = 1'b0;
        for (int i = 0; i < NUM_CAND; i++) begin
            if (!w_found && w_pend[i]) begin
                w_sel       = t_cand'(i);
                w_sel_oh[i] = 1'b1;
                w_found     = 1'b1;
            end
        end
        w_last = (w_pend & ~w_sel_oh) == '0;
        w_kind = CAND_KIND[w_sel];
        unique case (w_sel) inside
            CAND_HDR_CR:                  w_mark = i_head.mark_a;
            CAND_END_BREAK, CAND_END_EOB: w_mark = i_head.mark_l;
            default:                      w_mark = i_head.mark_p;
        endcase
        w_load = !i_q_stat.empty && (!r_out_valid || !i_out_stall);
        o_pop  = w_load && w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_done      <= w_last ? '0 : (r_done | w_sel_oh);
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind <= w_kind;
            r_last <= w_last;
            r_name <= (w_kind == KIND_END) ? '0 : i_head.name;
            r_mark <= w_mark;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_record_kind       = r_kind;
    assign o_name_start_offset = r_name.start_off;
    assign o_name_end_offset   = r_name.end_off;
    assign o_name_line         = r_name.line;
    assign o_name_first_column = r_name.first_col;
    assign o_name_colon_column = r_name.colon_col;
    assign o_mark_offset       = r_mark.off;
    assign o_mark_line         = r_mark.line;
    assign o_mark_column       = r_mark.col;
    assign o_last_of_run       = r_last;

    a_done_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_stat.empty |-> ((i_head.en != '0) && ((r_done & ~i_head.en) == '0)))
        else $error("serializer progress out of step with head bundle");

endmodule

// ===== rtl/section_header_splitter_unit.sv =====
// Section header splitter top level: front end, bundle queue and record serializer.
// Depends on shs_pkg, shs_front, shs_queue, shs_back.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_data_byte, i_end_of_body
//  out     | output    | o_out_valid / i_out_stall | o_record_kind, o_name_*, o_mark_*,
//          |           |                           | o_last_of_run
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One byte per cycle is classified when not stalled; a byte causes zero to three records.
// Records leave one per cycle unless i_out_stall is high; a 4-entry bundle queue absorbs
// runs and output stalls, and o_in_stall is high only while that queue is full.
// Reset is synchronous, active low; the config port is always ready.
module section_header_splitter_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_end_of_body,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_record_kind,
    output shs_pkg::t_cnt                   o_name_start_offset,
    output shs_pkg::t_cnt                   o_name_end_offset,
    output shs_pkg::t_cnt                   o_name_line,
    output shs_pkg::t_cnt                   o_name_first_column,
    output shs_pkg::t_cnt                   o_name_colon_column,
    output shs_pkg::t_cnt                   o_mark_offset,
    output shs_pkg::t_cnt                   o_mark_line,
    output shs_pkg::t_cnt                   o_mark_column,
    output logic                            o_last_of_run,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [shs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  shs_pkg::t_cnt                   i_cfg_data
);
    import shs_pkg::*;

    logic    w_accept, w_push, w_pop;
    t_bundle w_bundle, w_head;
    t_q_stat w_q_stat;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_q_stat.full;
    assign w_accept    = i_in_valid && !w_q_stat.full;

    shs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_data_byte   (i_data_byte),
        .i_end_of_body (i_end_of_body),
        .i_cfg_wr      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_push        (w_push),
        .o_bundle      (w_bundle)
    );

    shs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_bundle (w_bundle),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_stat   (w_q_stat)
    );

    shs_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_head              (w_head),
        .i_q_stat            (w_q_stat),
        .o_pop               (w_pop),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_record_kind       (o_record_kind),
        .o_name_start_offset (o_name_start_offset),
        .o_name_end_offset   (o_name_end_offset),
        .o_name_line         (o_name_line),
        .o_name_first_column (o_name_first_column),
        .o_name_colon_column (o_name_colon_column),
        .o_mark_offset       (o_mark_offset),
        .o_mark_line         (o_mark_line),
        .o_mark_column       (o_mark_column),
        .o_last_of_run       (o_last_of_run)
    );

endmodule

// ===== bench/tb_section_header_splitter_unit.sv =====
`timescale 1ns / 100ps
// Self-checking bench for section_header_splitter_unit: directed and random text bodies, header and end records.
// Depends on shs_pkg and the section_header_splitter_unit RTL.
module tb_section_header_splitter_unit;
    import shs_pkg::*;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam t_cnt       CNT_MAX   = '1;

    localparam int NUM_PHASES   = 6;
    localparam int PHASE_BYTES  = 48;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 100;
    localparam int IDLE_LIMIT   = 400;
    localparam int SHOW_LIMIT   = 10;

    typedef struct packed {
        logic  kind;
        t_name name;
        t_mark mark;
        logic  last;
    } t_rec;

    class header_record_scoreboard;
        t_cnt        start_line_reg;
        t_cnt        start_col_reg;
        t_cnt        offset;
        t_cnt        line_no;
        t_cnt        col_no;
        logic [2:0]  phase;
        bit          cr_seen;
        bit          open_sec;
        bit          fresh;
        t_name       name_hold;
        t_mark       line_mark;
        t_rec        run_q[$];
        t_rec        awaited_records[$];
        int          errors;

        function new();
            start_line_reg = 1;
            start_col_reg  = 1;
            errors         = 0;
            restart();
        endfunction

        function void restart();
            offset    = '0;
            line_no   = start_line_reg;
            col_no    = start_col_reg;
            phase     = PH_LEAD;
            cr_seen   = 0;
            open_sec  = 0;
            name_hold = '0;
            line_mark = '{'0, line_no, col_no};
            fresh     = 1;
        endfunction

        function t_cnt sat_inc(t_cnt x);
            return (x == CNT_MAX) ? x : x + 1'b1;
        endfunction

        function bit is_label_byte(logic [7:0] b);
            return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
                   (b >= "0" && b <= "9") || b == CH_USCORE || b == CH_DASH;
        endfunction

        function t_mark here();
            return '{offset, line_no, col_no};
        endfunction

        function void put(logic kind, t_mark mk);
            t_rec r;
            r.kind = kind;
            r.name = (kind == KIND_HEADER) ? name_hold : '0;
            r.mark = mk;
            r.last = 1'b0;
            run_q = {run_q, r};
            if (kind == KIND_HEADER) open_sec = 1;
        endfunction

        function void new_line(t_mark mk);
            line_mark = mk;
            phase     = PH_LEAD;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, t_cnt value);
            if (idx == CFG_START_LINE) start_line_reg = value;
            else if (idx == CFG_START_COL) start_col_reg = value;
            if (fresh) restart();
        endfunction

        function void note_byte(logic [7:0] b, logic eob);
            bit hdr;
            bit done;
            bit ws;
            done  = 0;
            fresh = 0;
            run_q.delete();
            if (cr_seen) begin
                hdr     = (phase == PH_PEND);
                cr_seen = 0;
                if (b == CH_LF) begin
                    offset = sat_inc(offset);
                    if (hdr) put(KIND_HEADER, here());
                    new_line(here());
                    done = 1;
                end else begin
                    if (hdr) put(KIND_HEADER, here());
                    new_line(here());
                end
            end
            if (!done) begin
                if (b == CH_CR || b == CH_LF) begin
                    hdr = (phase == PH_TAIL);
                    if (hdr && open_sec) put(KIND_END, line_mark);
                    offset  = sat_inc(offset);
                    line_no = sat_inc(line_no);
                    col_no  = 1;
                    if (b == CH_LF) begin
                        if (hdr) put(KIND_HEADER, here());
                        new_line(here());
                    end else begin
                        cr_seen = 1;
                        phase   = hdr ? PH_PEND : PH_LEAD;
                    end
                end else begin
                    ws = (b == CH_SPACE || b == CH_TAB);
                    case (phase)
                        PH_LEAD: begin
                            if (is_label_byte(b)) begin
                                name_hold.start_off = offset;
                                name_hold.line      = line_no;
                                name_hold.first_col = col_no;
                                phase = PH_NAME;
                            end else if (!ws) begin
                                phase = PH_REJECT;
                            end
                        end
                        PH_NAME: begin
                            if (b == CH_COLON) begin
                                name_hold.end_off   = offset;
                                name_hold.colon_col = col_no;
                                phase = PH_TAIL;
                            end else if (!is_label_byte(b)) begin
                                phase = PH_REJECT;
                            end
                        end
                        PH_TAIL: begin
                            if (!ws) phase = PH_REJECT;
                        end
                        default: phase = PH_REJECT;
                    endcase
                    offset = sat_inc(offset);
                    col_no = sat_inc(col_no);
                end
            end
            if (eob) begin
                if (cr_seen && phase == PH_PEND) begin
                    put(KIND_HEADER, here());
                end else if (!cr_seen && phase == PH_TAIL) begin
                    if (open_sec) put(KIND_END, line_mark);
                    put(KIND_HEADER, here());
                end
                if (open_sec) put(KIND_END, here());
                restart();
            end
            if (run_q.size() > 0) run_q[run_q.size()-1].last = 1'b1;
            foreach (run_q[i]) awaited_records = {awaited_records, run_q[i]};
        endfunction

        function string show(t_rec r);
            return $sformatf({"kind=%0d name=%0d..%0d line=%0d col=%0d..%0d ",
                              "mark=%0d/%0d/%0d last=%0d"},
                             r.kind, r.name.start_off, r.name.end_off, r.name.line,
                             r.name.first_col, r.name.colon_col, r.mark.off, r.mark.line,
                             r.mark.col, r.last);
        endfunction

        function void check_record(t_rec got);
            t_rec want;
            bit   bad;
            if (awaited_records.size() == 0) begin
                if (errors < SHOW_LIMIT) $display("unexpected record: %s", show(got));
                errors++;
                return;
            end
            want = awaited_records.pop_front();
            bad = (got.kind !== want.kind) ||
                  (got.name.start_off !== want.name.start_off) ||
                  (got.name.end_off !== want.name.end_off) ||
                  (got.name.line !== want.name.line) ||
                  (got.name.first_col !== want.name.first_col) ||
                  (got.name.colon_col !== want.name.colon_col) ||
                  (got.mark.off !== want.mark.off) ||
                  (got.mark.line !== want.mark.line) ||
                  (got.mark.col !== want.mark.col) ||
                  (got.last !== want.last);
            if (bad) begin
                if (errors < SHOW_LIMIT) begin
                    $display("record mismatch at %0t", $realtime);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        i_end_of_body;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_record_kind;
    t_cnt        o_name_start_offset;
    t_cnt        o_name_end_offset;
    t_cnt        o_name_line;
    t_cnt        o_name_first_column;
    t_cnt        o_name_colon_column;
    t_cnt        o_mark_offset;
    t_cnt        o_mark_line;
    t_cnt        o_mark_column;
    logic        o_last_of_run;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    t_cnt        i_cfg_data;

    header_record_scoreboard sb;
    logic [7:0] body_q[$];
    bit         quiet;
    bit         hold_req;
    int         idle_cycles;
    int         phase_bytes;

    section_header_splitter_unit uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_data_byte         (i_data_byte),
        .i_end_of_body       (i_end_of_body),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_record_kind       (o_record_kind),
        .o_name_start_offset (o_name_start_offset),
        .o_name_end_offset   (o_name_end_offset),
        .o_name_line         (o_name_line),
        .o_name_first_column (o_name_first_column),
        .o_name_colon_column (o_name_colon_column),
        .o_mark_offset       (o_mark_offset),
        .o_mark_line         (o_mark_line),
        .o_mark_column       (o_mark_column),
        .o_last_of_run       (o_last_of_run),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin : monitor
        t_rec got;
        bit   moved;
        moved = 0;
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            sb.write_reg(i_cfg_index, i_cfg_data);
            moved = 1;
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            sb.note_byte(i_data_byte, i_end_of_body);
            moved = 1;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.kind = o_record_kind;
            got.name = '{o_name_start_offset, o_name_end_offset, o_name_line,
                         o_name_first_column, o_name_colon_column};
            got.mark = '{o_mark_offset, o_mark_line, o_mark_column};
            got.last = o_last_of_run;
            sb.check_record(got);
            moved = 1;
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    initial begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : receiver
        int w;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            w = quiet ? 0 : $urandom_range(0, 5);
            if (w > 0) begin
                i_out_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    function automatic logic [7:0] blank_char();
        return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
    endfunction

    function automatic logic [7:0] name_char();
        case ($urandom_range(0, 4))
            0:       return 8'h61 + 8'($urandom_range(0, 25));
            1:       return 8'h41 + 8'($urandom_range(0, 25));
            2:       return 8'h30 + 8'($urandom_range(0, 9));
            3:       return CH_USCORE;
            default: return CH_DASH;
        endcase
    endfunction

    function automatic void add_byte(logic [7:0] b);
        body_q = {body_q, b};
    endfunction

    function automatic void add_text(string s);
        foreach (s[i]) add_byte(s[i]);
    endfunction

    function automatic void gen_break();
        case ($urandom_range(0, 2))
            0: add_byte(CH_LF);
            1: add_byte(CH_CR);
            default: begin
                add_byte(CH_CR);
                add_byte(CH_LF);
            end
        endcase
    endfunction

    function automatic void gen_line();
        int kind;
        int n;
        kind = $urandom_range(0, 9);
        if (kind <= 4) begin
            n = $urandom_range(0, 2);
            repeat (n) add_byte(blank_char());
            n = $urandom_range(1, 5);
            repeat (n) add_byte(name_char());
            add_byte(CH_COLON);
            n = $urandom_range(0, 2);
            repeat (n) add_byte(blank_char());
            if ($urandom_range(0, 7) == 0) add_byte(8'($urandom_range(33, 126)));
        end else if (kind <= 6) begin
            n = $urandom_range(1, 6);
            repeat (n) add_byte(8'($urandom_range(32, 126)));
        end else if (kind == 8) begin
            n = $urandom_range(1, 4);
            repeat (n) add_byte(8'($urandom_range(0, 255)));
        end else if (kind == 9) begin
            if ($urandom_range(0, 1)) begin
                add_byte(CH_COLON);
            end else begin
                n = $urandom_range(1, 3);
                repeat (n) add_byte(name_char());
                add_byte(8'($urandom_range(33, 44)));
                add_byte(CH_COLON);
            end
        end
    endfunction

    function automatic void gen_body();
        int lines;
        lines = $urandom_range(1, 5);
        for (int i = 0; i < lines; i++) begin
            gen_line();
            if (i < lines - 1 || $urandom_range(0, 2) != 0) gen_break();
        end
    endfunction

    task automatic send_byte(logic [7:0] b, logic eob);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_data_byte   <= b;
        i_end_of_body <= eob;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_body(bit terminate);
        for (int i = 0; i < body_q.size(); i++)
            send_byte(body_q[i], terminate && (i == body_q.size() - 1));
        phase_bytes += body_q.size();
        body_q.delete();
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.awaited_records.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(t_cnt line_val, t_cnt col_val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_START_LINE;
        i_cfg_data  <= line_val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_START_COL;
        i_cfg_data  <= col_val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        bit   paused;
        bit   terminate;
        t_cnt line_val;
        t_cnt col_val;
        sb          = new();
        idle_cycles = 0;
        quiet       = 0;
        hold_req    = 0;
        phase_bytes = 0;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_data_byte   <= '0;
        i_end_of_body <= 1'b0;
        i_out_stall   <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_START_LINE;
        i_cfg_data    <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_config(32'd1, 32'd1);

        // header by LF, header by CR then other byte, rejected CRLF line, CR at end of body
        add_text(" _z9:\t\n");
        add_text("-A:");
        add_byte(CH_CR);
        add_text("x");
        add_byte(8'hFF);
        add_byte(8'h00);
        add_byte(CH_CR);
        add_text("\n0Z:");
        add_byte(CH_CR);
        send_body(1);
        // header by CRLF, header on last line without break
        add_text("Q:");
        add_byte(CH_CR);
        add_text("\nR:");
        send_body(1);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drain();
            case (ph)
                0: begin line_val = CNT_MAX;        col_val = CNT_MAX;        end
                1: begin line_val = '0;             col_val = '0;             end
                2: begin line_val = CNT_MAX - 2;    col_val = CNT_MAX - 3;    end
                4: begin line_val = 32'd1;          col_val = 32'd1;          end
                default: begin line_val = $urandom(); col_val = $urandom();   end
            endcase
            set_config(line_val, col_val);
            quiet       = (ph == 1 || ph == 4);
            hold_req    = (ph == 1);
            phase_bytes = 0;
            paused      = 0;
            while (phase_bytes < PHASE_BYTES) begin
                if (ph == 3 && phase_bytes >= PHASE_BYTES / 2 && !paused) begin
                    i_in_valid <= 1'b0;
                    do @(posedge i_clk); while (sb.awaited_records.size() != 0);
                    paused = 1;
                end
                gen_body();
                terminate = (ph == NUM_PHASES - 1) ||
                            (phase_bytes + body_q.size() < PHASE_BYTES) ||
                            ($urandom_range(0, 1) == 1);
                send_body(terminate);
            end
        end
        quiet = 0;
        wait_drain();
        if (sb.errors == 0 && sb.awaited_records.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/shs_pkg.sv
rtl/shs_front.sv
rtl/shs_queue.sv
rtl/shs_back.sv
rtl/section_header_splitter_unit.sv
bench/tb_section_header_splitter_unit.sv
